// File: src/mns_pkg.sv
// Shared types and constants of the melody note sequencer.
package mns_pkg;

  // Input action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_WRITE = 2'd3;

  // Field widths fixed by the channel format
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned IDX8_W  = 8;
  localparam int unsigned PITCH_W = 8;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned MS_W    = 16;

  // Tempo arithmetic: sixteenth = floor(60000 / (4 * bpm))
  localparam int unsigned MS_PER_MINUTE = 60000;
  localparam int unsigned SIX_W         = 14;
  localparam logic [SIX_W-1:0] SIXTEENTH_NUM   = SIX_W'(MS_PER_MINUTE / 4);
  localparam logic [SIX_W-1:0] SIXTEENTH_RESET = SIX_W'(MS_PER_MINUTE / 4 / 120);
  localparam logic [7:0]       TEMPO_MIN       = 8'd1;
  localparam int unsigned      DIV_STEPS       = SIX_W;

  // Gap between notes in ms
  localparam logic [MS_W-1:0] GAP_MS = MS_W'(20);

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_WRITE
  } cmd_kind_t;

  // Classified request handed from front to back
  typedef struct packed {
    cmd_kind_t            kind;
    logic [IDX8_W-1:0]    idx;
    logic [PITCH_W-1:0]   pitch;
    logic [LEN_W-1:0]     length;
    logic                 end_mark;
  } cmd_t;

  // Tempo unit status
  typedef struct packed {
    logic             busy;
    logic [SIX_W-1:0] sixteenth_ms;
  } tempo_t;

endpackage

// File: src/mns_if.sv
// Request and result channel interfaces of the melody note sequencer.
interface mns_in_if;
  import mns_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [IDX8_W-1:0]    entry_index;
  logic [PITCH_W-1:0]   entry_pitch;
  logic [LEN_W-1:0]     entry_length;
  logic                 entry_end;

  modport source (
    output valid, action, entry_index, entry_pitch, entry_length, entry_end,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, entry_pitch, entry_length, entry_end,
    output ready
  );
endinterface

interface mns_out_if;
  import mns_pkg::*;
  logic               valid;
  logic               ready;
  logic               note_start;
  logic [PITCH_W-1:0] note_pitch;
  logic [MS_W-1:0]    sound_ms;
  logic               playing;

  modport source (
    output valid, note_start, note_pitch, sound_ms, playing,
    input  ready
  );
  modport sink (
    input  valid, note_start, note_pitch, sound_ms, playing,
    output ready
  );
endinterface

// File: src/melody_note_sequencer_top.sv
// Melody note sequencer: plays notes from a store on millisecond ticks.
//
// Usage:
//   in_ch carries requests: tick, start, stop or store write (valid/ready).
//   out_ch returns exactly one result per request, in request order.
//   cfg_we/cfg_wdata write the tempo in bpm; write only while idle.
// Request flow:
//   An accepted request waits in the queue until the back end is idle;
//   the back end takes a tick through pop, multiply and result, and any
//   other request through pop and result, and pops the next request only
//   once the result is loaded. A two-entry queue lets the input run ahead.
//   A tempo write starts a serial divide; requests queue during it and are
//   executed once the new sixteenth length is ready.
// Reset:
//   Synchronous, active low. Tempo returns to 120 bpm (125 ms sixteenth),
//   playback is stopped. The note store is not cleared.
// Stalls:
//   When out_ch.ready is low the result is held; the back end stops and
//   the queue fills, then in_ch.ready drops.
module melody_note_sequencer_top #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned PITCH_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  mns_in_if.sink      in_ch,
  mns_out_if.source   out_ch
);
  import mns_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  tempo_t  tempo;

  mns_tempo_div u_tempo (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tempo     (tempo)
  );

  mns_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  mns_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  mns_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .PITCH_BITS  (PITCH_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .tempo   (tempo),
    .out_ch  (out_ch)
  );

endmodule

// File: src/mns_tempo_div.sv
// Tempo unit: derives the sixteenth-note length in ms with a serial divider.
module mns_tempo_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output mns_pkg::tempo_t   tempo
);
  import mns_pkg::*;

  logic                  busy_r;
  logic [3:0]            cnt_r;
  logic [7:0]            div_r;
  logic [SIX_W-1:0]      num_r;
  logic [8:0]            rem_r;
  logic [SIX_W-1:0]      quo_r;
  logic [SIX_W-1:0]      six_r;
  logic [8:0]            trial;
  logic                  ge;

  // One quotient bit per cycle, restoring division
  assign trial = {rem_r[7:0], num_r[SIX_W-1]};
  assign ge    = (trial >= {1'b0, div_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      six_r  <= SIXTEENTH_RESET;
    end else if (cfg_we) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == 4'(DIV_STEPS - 1))) begin
      busy_r <= 1'b0;
      six_r  <= {quo_r[SIX_W-2:0], ge};
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cfg_we) begin
      div_r <= (cfg_wdata == 8'd0) ? TEMPO_MIN : cfg_wdata;
      num_r <= SIXTEENTH_NUM;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (trial - {1'b0, div_r}) : trial;
      quo_r <= {quo_r[SIX_W-2:0], ge};
      num_r <= {num_r[SIX_W-2:0], 1'b0};
      cnt_r <= cnt_r + 4'd1;
    end
  end

  assign tempo.busy         = busy_r;
  assign tempo.sixteenth_ms = six_r;

endmodule

// File: src/mns_front.sv
// Front end: takes requests, decodes the action and wraps the store index.
module mns_front #(
  parameter int unsigned STORE_DEPTH = 256
) (
  mns_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output mns_pkg::cmd_t  q_cmd
);
  import mns_pkg::*;

  typedef logic [IDX8_W-1:0] wrap_tab_t [256];

  // Index modulo store depth, built at elaboration
  function automatic wrap_tab_t build_wrap();
    wrap_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = IDX8_W'(i % STORE_DEPTH);
    end
    return t;
  endfunction

  localparam wrap_tab_t WRAP_TAB = build_wrap();

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Classify the request
  always_comb begin
    q_cmd.idx      = WRAP_TAB[in_ch.entry_index];
    q_cmd.pitch    = in_ch.entry_pitch;
    q_cmd.length   = in_ch.entry_length;
    q_cmd.end_mark = in_ch.entry_end;
    unique case (in_ch.action)
      ACT_TICK:  q_cmd.kind = CMD_TICK;
      ACT_START: q_cmd.kind = CMD_START;
      ACT_STOP:  q_cmd.kind = CMD_STOP;
      ACT_WRITE: q_cmd.kind = CMD_WRITE;
      default:   q_cmd.kind = CMD_TICK;
    endcase
  end

endmodule

// File: src/mns_queue.sv
// Two-entry request queue between front and back.
module mns_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mns_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output mns_pkg::cmd_t  head_cmd,
  output logic           full,
  output logic           empty
);
  import mns_pkg::*;

  cmd_t        slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign head_cmd = slot_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// File: src/mns_back.sv
// Back end: note store, playback state and result register.
module mns_back #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned PITCH_BITS  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  mns_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  input  mns_pkg::tempo_t  tempo,
  mns_out_if.source        out_ch
);
  import mns_pkg::*;

  localparam int unsigned IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned ENT_W = PITCH_BITS + LEN_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_RES  = 2'd2;

  logic [ENT_W-1:0]    store [STORE_DEPTH];

  logic [1:0]          state_r;
  cmd_t                cmd_r;
  logic                active_r;
  logic [IDX_W-1:0]    pos_r;
  logic [MS_W-1:0]     rem_r;
  logic [ENT_W-1:0]    rd_r;
  logic                fire_r;
  logic [MS_W-1:0]     prod_r;

  logic                out_valid_r;
  logic                out_start_r;
  logic [PITCH_W-1:0]  out_pitch_r;
  logic [MS_W-1:0]     out_sound_r;
  logic                out_play_r;

  logic                store_we;
  logic [IDX_W-1:0]    store_wa;
  logic [ENT_W-1:0]    store_wd;
  logic [PITCH_BITS-1:0] rd_pitch;
  logic [LEN_W-1:0]    rd_len;
  logic                rd_end;
  logic [15:0]         pitch16;
  logic [21:0]         prod_full;
  logic                can_load;
  logic                load;
  logic                due;
  logic [IDX_W-1:0]    pos_inc;

  assign q_pop    = (state_r == S_IDLE) && !q_empty && !tempo.busy;
  assign store_we = q_pop && (q_cmd.kind == CMD_WRITE);
  assign store_wa = IDX_W'(q_cmd.idx);
  assign store_wd = {q_cmd.end_mark, q_cmd.length, PITCH_BITS'(q_cmd.pitch)};

  assign rd_pitch  = rd_r[PITCH_BITS-1:0];
  assign rd_len    = rd_r[PITCH_BITS +: LEN_W];
  assign rd_end    = rd_r[ENT_W-1];
  assign pitch16   = 16'(rd_pitch);
  assign prod_full = 22'(rd_len) * 22'(tempo.sixteenth_ms);
  assign due       = active_r && (rem_r == '0);
  assign can_load  = !out_valid_r || out_ch.ready;
  assign load      = (state_r == S_RES) && can_load;
  assign pos_inc   = (pos_r == IDX_W'(STORE_DEPTH - 1)) ? '0 : pos_r + IDX_W'(1);

  // Note store: write on a write request, read the play position on every pop
  always_ff @(posedge clk) begin
    if (store_we) store[store_wa] <= store_wd;
    if (q_pop)    rd_r <= store[pos_r];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
      pos_r    <= '0;
      rem_r    <= '0;
      fire_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            fire_r <= 1'b0;
            unique case (q_cmd.kind)
              CMD_TICK: begin
                if (rem_r != '0) rem_r <= rem_r - MS_W'(1);
                state_r <= S_MUL;
              end
              CMD_START: begin
                pos_r    <= '0;
                active_r <= 1'b1;
                rem_r    <= MS_W'(1);
                state_r  <= S_RES;
              end
              CMD_STOP: begin
                active_r <= 1'b0;
                state_r  <= S_RES;
              end
              CMD_WRITE: state_r <= S_RES;
              default:   state_r <= S_RES;
            endcase
          end
        end
        S_MUL: begin
          fire_r <= due && !rd_end;
          if (due && rd_end) active_r <= 1'b0;
          state_r <= S_RES;
        end
        S_RES: begin
          if (can_load) begin
            if (fire_r) begin
              rem_r <= prod_r;
              pos_r <= pos_inc;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Length product, registered ahead of the gap subtract
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) prod_r <= prod_full[MS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) cmd_r <= cmd_r;
    else if (q_pop)       cmd_r <= q_cmd;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_start_r <= fire_r;
      out_pitch_r <= fire_r ? pitch16[PITCH_W-1:0] : '0;
      out_sound_r <= (fire_r && (prod_r >= GAP_MS)) ? prod_r - GAP_MS : '0;
      out_play_r  <= fire_r ? ((prod_r != '0) || active_r)
                            : ((rem_r != '0) || active_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.note_start = out_start_r;
  assign out_ch.note_pitch = out_pitch_r;
  assign out_ch.sound_ms   = out_sound_r;
  assign out_ch.playing    = out_play_r;

  // Checks
  a_pop_after_tempo: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !tempo.busy)
    else $error("request popped while tempo unit busy");

  a_mul_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cmd_r.kind == CMD_TICK))
    else $error("multiply state entered for a non-tick request");

  a_note_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && fire_r) |=> (rem_r == $past(prod_r)))
    else $error("countdown not loaded with note length");

  a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !fire_r) |=> (out_pitch_r == '0 && out_sound_r == '0 && !out_start_r))
    else $error("result without a note carries note data");

endmodule
